[rtl/core/tlpq_pkg.sv]
package tlpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int LEVELS      = 3;

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = $clog2(LEVELS * QUEUE_DEPTH);
	localparam int LVL_W     = 2;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int PAYLOAD_W = 32;

	typedef logic [LVL_W-1:0]  level_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_GET   = 2'd1,
		KIND_FLUSH = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam level_t LVL_HIGH = 2'd0;
	localparam level_t LVL_MED  = 2'd1;
	localparam level_t LVL_LOW  = 2'd2;

	// Memory operation and result info for one accepted transaction
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		addr_t   addr;
		status_t status;
		level_t  lvl;
	} op_t;

	// Start of each level's region in the entry memory
	function automatic addr_t base_addr(level_t q);
		addr_t b;
		b = '0;
		unique case (q)
			LVL_MED: b = ADDR_W'(QUEUE_DEPTH);
			LVL_LOW: b = ADDR_W'(2 * QUEUE_DEPTH);
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic ptr_t next_slot(ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

[rtl/core/tlpq_if.sv]
interface tlpq_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [tlpq_pkg::KIND_W-1:0]    kind;
	logic [tlpq_pkg::LVL_W-1:0]     level;
	logic [tlpq_pkg::PAYLOAD_W-1:0] payload;

	modport source (output valid, kind, level, payload, input ready);
	modport sink   (input valid, kind, level, payload, output ready);
endinterface

interface tlpq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tlpq_pkg::STATUS_W-1:0]  status;
	logic [tlpq_pkg::LVL_W-1:0]     out_level;
	logic [tlpq_pkg::PAYLOAD_W-1:0] out_payload;

	modport source (output valid, status, out_level, out_payload, input ready);
	modport sink   (input valid, status, out_level, out_payload, output ready);
endinterface

[rtl/core/tlpq_ctrl.sv]
module tlpq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [tlpq_pkg::KIND_W-1:0] kind,
	input  tlpq_pkg::level_t            level,
	output tlpq_pkg::op_t               op
);
	import tlpq_pkg::*;

	ptr_t   head_q [LEVELS];
	ptr_t   tail_q [LEVELS];
	cnt_t   cnt_q  [LEVELS];

	kind_t  k;
	level_t q_add;
	level_t q_get;
	logic   any_q;
	level_t sel_q;

	assign k     = kind_t'(kind);
	assign q_add = (level >= LVL_LOW) ? LVL_LOW : level;

	always_comb begin
		any_q = 1'b1;
		q_get = LVL_HIGH;
		priority if (cnt_q[0] != '0) begin
			q_get = LVL_HIGH;
		end else if (cnt_q[1] != '0) begin
			q_get = LVL_MED;
		end else if (cnt_q[2] != '0) begin
			q_get = LVL_LOW;
		end else begin
			any_q = 1'b0;
		end
	end

	assign sel_q = (k == KIND_GET) ? q_get : q_add;

	always_comb begin
		op        = '0;
		op.status = ST_OK;
		unique case (k)
			KIND_ADD: begin
				if (cnt_q[sel_q] == CNT_W'(QUEUE_DEPTH)) begin
					op.status = ST_FULL;
				end else begin
					op.wr_en = 1'b1;
					op.addr  = base_addr(sel_q) + ADDR_W'(tail_q[sel_q]);
				end
			end
			KIND_GET: begin
				if (!any_q) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd_en = 1'b1;
					op.lvl   = sel_q;
					op.addr  = base_addr(sel_q) + ADDR_W'(head_q[sel_q]);
				end
			end
			KIND_FLUSH, KIND_NOP: begin
				op.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (accept) begin
			if (k == KIND_FLUSH) begin
				for (int i = 0; i < LEVELS; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
					cnt_q[i]  <= '0;
				end
			end else if (op.wr_en) begin
				tail_q[sel_q] <= next_slot(tail_q[sel_q]);
				cnt_q[sel_q]  <= cnt_q[sel_q] + 1'b1;
			end else if (op.rd_en) begin
				head_q[sel_q] <= next_slot(head_q[sel_q]);
				cnt_q[sel_q]  <= cnt_q[sel_q] - 1'b1;
			end
		end
	end

endmodule

[rtl/core/three_level_priority_queue.sv]
// Three-level strict-priority queue.
// cmd channel: one transaction per command. kind selects add, get or flush;
// an add appends payload to the queue of its level (level 3 counts as low),
// a get pops the head of the highest-priority non-empty queue.
// rsp channel: exactly one transaction per command, in command order, with
// status ok, empty (get with nothing queued) or full (add refused), the
// source level and the popped entry; level and payload are zero otherwise.
// A taken command moves to the first stage, then to the response register.
// Throughput: one command per cycle while rsp is not stalled. Pointers and
// counts update in the cycle a command is taken, so an entry written by an
// add is readable by a get in the very next cycle; the entry memory has one
// write and one read port with a registered read that feeds the response
// register. Reset clears all pointers and counts and empties the pipeline;
// the entry memory is not cleared and needs no sweep.
// When the receiver stalls, the response register holds, one more command
// is taken into the first stage, and then cmd.ready drops until rsp drains.
module three_level_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	tlpq_cmd_if.sink            cmd,
	tlpq_rsp_if.source          rsp
);
	import tlpq_pkg::*;

	data_t   mem [LEVELS * QUEUE_DEPTH];
	data_t   rdata_q;

	op_t     op;
	logic    accept;
	logic    advance;

	logic    v_s1;
	status_t status_s1;
	level_t  lvl_s1;
	logic    get_s1;

	logic                 out_v_q;
	status_t              status_q;
	level_t               lvl_q;
	logic [PAYLOAD_W-1:0] payload_q;

	assign accept    = cmd.valid && cmd.ready;
	assign advance   = v_s1 && (!out_v_q || rsp.ready);
	assign cmd.ready = !v_s1 || advance;

	tlpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (cmd.kind),
		.level  (cmd.level),
		.op     (op)
	);

	always_ff @(posedge clk) begin
		if (accept && op.wr_en) begin
			mem[op.addr] <= cmd.payload[DATA_WIDTH-1:0];
		end
		if (accept && op.rd_en) begin
			rdata_q <= mem[op.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= op.status;
			lvl_s1    <= op.lvl;
			get_s1    <= op.rd_en;
		end
		if (advance) begin
			status_q  <= status_s1;
			lvl_q     <= lvl_s1;
			payload_q <= get_s1 ? PAYLOAD_W'(rdata_q) : '0;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = status_q;
	assign rsp.out_level   = lvl_q;
	assign rsp.out_payload = payload_q;

endmodule

[sim/tlpq_checker.sv]
module tlpq_checker
	import tlpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tlpq_cmd_if  cmd,
	tlpq_rsp_if  rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t                status;
		level_t                 lvl;
		logic [PAYLOAD_W-1:0]   data;
	} reply_t;

	// Mirror of the three level queues and the replies still owed by the block
	data_t  held [LEVELS][$];
	reply_t replies_due[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic reply_t apply_command(kind_t k, level_t lvl, logic [PAYLOAD_W-1:0] pl);
		reply_t r;
		int     q;
		r.status = ST_OK;
		r.lvl    = LVL_HIGH;
		r.data   = '0;
		case (k)
			KIND_ADD: begin
				// level 3 lands in the low queue
				q = (lvl > LVL_LOW) ? int'(LVL_LOW) : int'(lvl);
				if (held[q].size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					held[q].push_back(data_t'(pl));
				end
			end
			KIND_GET: begin
				r.status = ST_EMPTY;
				for (q = 0; q < LEVELS; q++) begin
					if (r.status == ST_EMPTY && held[q].size() != 0) begin
						r.status = ST_OK;
						r.lvl    = level_t'(q);
						r.data   = PAYLOAD_W'(held[q].pop_front());
					end
				end
			end
			KIND_FLUSH: begin
				for (q = 0; q < LEVELS; q++) begin
					held[q].delete();
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : watch
		reply_t want;
		logic   bad;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				replies_due.push_back(apply_command(kind_t'(cmd.kind), level_t'(cmd.level),
					cmd.payload));
			end
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected response status %0d level %0d payload %h",
							$realtime, rsp.status, rsp.out_level, rsp.out_payload);
					end
				end else begin
					want = replies_due.pop_front();
					bad  = (rsp.status != want.status) || (rsp.out_level != want.lvl) ||
						(rsp.out_payload != want.data);
					if (bad) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch status %0d/%0d level %0d/%0d payload %h/%h (exp/got)",
								$realtime, want.status, rsp.status, want.lvl, rsp.out_level,
								want.data, rsp.out_payload);
						end
					end
				end
			end
			pending = replies_due.size();
		end
	end

endmodule

[sim/three_level_priority_queue_tb.sv]
module three_level_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlpq_pkg::*;

	localparam int ITEM_TARGET = 450;
	localparam int IDLE_LIMIT  = 2000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   replies_owed;
	int   sent;
	logic tx_quiet;

	tlpq_cmd_if cmd_ch();
	tlpq_rsp_if rsp_ch();

	three_level_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	tlpq_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.errors  (fail_count),
		.pending (replies_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [PAYLOAD_W-1:0] pick_payload();
		logic [PAYLOAD_W-1:0] w;
		case ($urandom_range(0, 7))
			0:       w = '0;
			1:       w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic level_t pick_level();
		return level_t'($urandom_range(0, 3));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic issue(kind_t k, level_t lvl, logic [PAYLOAD_W-1:0] pl);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.kind    <= k;
		cmd_ch.level   <= lvl;
		cmd_ch.payload <= pl;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		sent++;
		@(negedge clk);
	endtask

	// Hold off new commands until every response is back
	task automatic drain_replies();
		cmd_ch.valid <= 1'b0;
		while (replies_owed != 0) @(negedge clk);
	endtask

	initial begin : rsp_side
		int   n;
		int   left;
		logic rx_quiet;
		rsp_ch.ready = 1'b0;
		rx_quiet     = 1'b0;
		left         = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (left == 0) begin
				rx_quiet = ($urandom_range(0, 3) == 0);
				left     = $urandom_range(10, 40);
			end
			left--;
			n = rx_quiet ? 0 : $urandom_range(0, 14);
			if (n != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int     seg;
		int     n;
		int     r;
		logic   paused;
		level_t lvl;
		cmd_ch.valid   = 1'b0;
		cmd_ch.kind    = KIND_NOP;
		cmd_ch.level   = LVL_HIGH;
		cmd_ch.payload = '0;
		arst_n         = 1'b0;
		sent           = 0;
		tx_quiet       = 1'b0;
		paused         = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty get, extremes, priority order, level 3, no-op, flush
		issue(KIND_GET,   LVL_HIGH, 32'h0);
		issue(KIND_ADD,   LVL_HIGH, 32'h0000_0000);
		issue(KIND_ADD,   LVL_MED,  32'hFFFF_FFFF);
		issue(KIND_ADD,   level_t'(3), 32'hA5A5_A5A5);
		issue(KIND_ADD,   LVL_LOW,  32'h5A5A_5A5A);
		issue(KIND_GET,   LVL_LOW,  32'hFFFF_FFFF);
		issue(KIND_GET,   level_t'(3), 32'h0);
		issue(KIND_GET,   LVL_HIGH, 32'h1234_5678);
		issue(KIND_GET,   LVL_MED,  32'h0);
		issue(KIND_GET,   LVL_HIGH, 32'h0);
		issue(KIND_NOP,   level_t'(3), 32'hFFFF_FFFF);
		issue(KIND_ADD,   LVL_LOW,  32'hDEAD_BEEF);
		issue(KIND_ADD,   LVL_HIGH, 32'h8000_0001);
		issue(KIND_FLUSH, level_t'(3), 32'hFFFF_FFFF);
		issue(KIND_GET,   LVL_HIGH, 32'h0);
		issue(KIND_ADD,   LVL_MED,  32'h7FFF_FFFE);
		issue(KIND_GET,   level_t'(3), 32'h0);
		drain_replies();

		while (sent < ITEM_TARGET) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			seg      = $urandom_range(0, 6);
			case (seg)
				0: begin
					// add 10 to 20 entries to one queue; this can pass full and wrap the pointer
					lvl = pick_level();
					n   = $urandom_range(10, 20);
					repeat (n) issue(KIND_ADD, lvl, pick_payload());
				end
				1: begin
					n = $urandom_range(4, 24);
					repeat (n) issue(KIND_GET, pick_level(), pick_payload());
				end
				2: begin
					n = $urandom_range(2, 8);
					repeat (n) issue(KIND_ADD, pick_level(), pick_payload());
					issue(KIND_FLUSH, pick_level(), pick_payload());
					n = $urandom_range(1, 4);
					repeat (n) issue(KIND_GET, pick_level(), pick_payload());
				end
				default: begin
					n = $urandom_range(10, 30);
					repeat (n) begin
						r = $urandom_range(0, 39);
						if (r < 20) begin
							issue(KIND_ADD, pick_level(), pick_payload());
						end else if (r < 37) begin
							issue(KIND_GET, pick_level(), pick_payload());
						end else if (r < 39) begin
							issue(KIND_NOP, pick_level(), pick_payload());
						end else begin
							issue(KIND_FLUSH, pick_level(), pick_payload());
						end
					end
				end
			endcase
			if (!paused && sent >= ITEM_TARGET / 2) begin
				drain_replies();
				paused = 1'b1;
			end
		end

		cmd_ch.valid <= 1'b0;
		while (replies_owed != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && replies_owed == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
